// ===== rtl/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Shared widths, command codes and the byte unit's control and status types.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int NBITS_DEF = 1024;
  localparam int CMD_W     = 4;
  localparam int IDX_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int DATA_W    = 16;

  localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_TEST     = 4'd0,
    CMD_SET      = 4'd1,
    CMD_CLR      = 4'd2,
    CMD_SET_ALL  = 4'd3,
    CMD_CLR_ALL  = 4'd4,
    CMD_CNT_SET  = 4'd5,
    CMD_CNT_CLR  = 4'd6,
    CMD_FIND_SET = 4'd7,
    CMD_FIND_CLR = 4'd8
  } cmd_t;

  typedef struct packed {
    logic       invert;
    logic [7:0] mask;
  } unit_ctl_t;

  typedef struct packed {
    logic [3:0] cnt;
    logic       hit;
    logic [2:0] pos;
  } unit_res_t;

endpackage

// ===== rtl/bma_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bma_byte_unit.sv =====
// ----------------------------------------------------------------------------
// Bitmap byte unit
// Counts and locates the lowest matching bit of one masked bitmap byte.
// ----------------------------------------------------------------------------
module bma_byte_unit import bma_pkg::*; (
  input  logic [7:0] data_in,
  input  unit_ctl_t  ctl,
  output unit_res_t  res
);

  logic [7:0] bits;

  always_comb begin
    bits    = (ctl.invert ? ~data_in : data_in) & ctl.mask;
    res.cnt = '0;
    res.pos = '0;
    res.hit = |bits;
    for (int i = 0; i < 8; i++) begin
      res.cnt = res.cnt + 4'(bits[i]);
    end
    for (int i = 7; i >= 0; i--) begin
      if (bits[i]) begin
        res.pos = 3'(i);
      end
    end
  end

endmodule

// ===== rtl/bitmap_allocator_store.sv =====
// ----------------------------------------------------------------------------
// Bitmap allocator store
// Byte-organized bitmap with test, set, clear, fill, count and find requests.
// ----------------------------------------------------------------------------
// Requests enter on in_: in_tuser carries the command, in_tdata the bit index.
// Each request returns one result on out_. cfg_ writes the used size and is
// always ready; write it only while no request is in flight.
// States from the accepting edge to result valid:
//   test, set, clear            S_ACCESS (one read, one write-back), S_DONE
//   out-of-range index, set all,
//   clear all, unknown command  S_DONE only
//   count and find              S_SCAN over ceil(n/8) bytes, n the used size,
//                               at most 128 bytes with 1024 bits; the one
//                               RAM read port scans a byte per cycle
//                               through the byte unit. Find stops at the
//                               first matching byte.
// One request is worked on at a time; in_tready is high only while idle, so
// a new request is taken only after the last one leaves S_DONE.
// Set all and clear all drop the per-byte valid flags and load a fill value
// that invalid bytes read as. Reset clears the flags and fill value, so the
// bitmap reads as all zero at once, with no clearing pass; used size returns
// to 1024. A stalled result is held in the output register; one further
// request may be accepted and worked on, then the block waits for out_tready.
// ----------------------------------------------------------------------------
module bitmap_allocator_store import bma_pkg::*; #(
  parameter int NBITS = NBITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [9:0] bit position
  input  logic [CMD_W-1:0]  in_tuser,   // [3:0] command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [0] bit_value, [11:1] result_value,
                                        // [12] found, [13] index_error
  input  logic              cfg_tvalid,
  output logic              cfg_tready,
  input  logic [DATA_W-1:0] cfg_tdata   // [10:0] size_in_bits
);

  localparam int NBYTES    = (NBITS + 7) / 8;
  localparam int MEM_DEPTH = (NBYTES > 256) ? 256 : NBYTES;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SIZE_CAP  = (NBITS > 2047) ? 2047 : NBITS;

  typedef enum logic [1:0] {S_IDLE, S_ACCESS, S_SCAN, S_DONE} state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic                fill_r, fill_nxt;
  logic [MEM_DEPTH-1:0] valid_r, valid_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [8:0]          rd_byte_r, rd_byte_nxt;
  logic [8:0]          nbytes_r, nbytes_nxt;
  logic [SIZE_W-1:0]   acc_r, acc_nxt;
  logic                res_bit_r, res_bit_nxt;
  logic [SIZE_W-1:0]   res_val_r, res_val_nxt;
  logic                res_fnd_r, res_fnd_nxt;
  logic                res_err_r, res_err_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  logic [SIZE_W-1:0]   used;
  logic [11:0]         nb_sum;
  logic [8:0]          nbytes;
  logic [IDX_W-1:0]    in_idx;
  cmd_t                in_cmd;
  logic [AW-1:0]       in_addr;
  logic [AW-1:0]       next_addr;
  logic [8:0]          next_byte;
  logic                is_last;
  logic [7:0]          tail_mask;
  logic [7:0]          byte_now;
  logic [11:0]         find_idx;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;

  unit_ctl_t           u_ctl;
  unit_res_t           u_res;

  bma_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bma_byte_unit u_unit (
    .data_in (byte_now),
    .ctl     (u_ctl),
    .res     (u_res)
  );

  assign used      = (size_r > SIZE_W'(SIZE_CAP)) ? SIZE_W'(SIZE_CAP) : size_r;
  assign nb_sum    = {1'b0, used} + 12'd7;
  assign nbytes    = nb_sum[11:3];
  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_addr   = AW'(in_idx >> 3);
  assign next_byte = rd_byte_r + 9'd1;
  assign next_addr = AW'(next_byte);
  assign is_last   = (rd_byte_r == nbytes_r - 9'd1);
  assign tail_mask = 8'hFF >> (4'd8 - {1'b0, used[2:0]});
  assign byte_now  = rvalid_r ? ram_rdata : {8{fill_r}};
  assign find_idx  = {rd_byte_r, u_res.pos};

  assign u_ctl.invert = (cmd_r == CMD_CNT_CLR) || (cmd_r == CMD_FIND_CLR);
  assign u_ctl.mask   = (is_last && (used[2:0] != 3'd0)) ? tail_mask : 8'hFF;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    size_nxt       = size_r;
    fill_nxt       = fill_r;
    valid_nxt      = valid_r;
    rvalid_nxt     = rvalid_r;
    rd_byte_nxt    = rd_byte_r;
    nbytes_nxt     = nbytes_r;
    acc_nxt        = acc_r;
    res_bit_nxt    = res_bit_r;
    res_val_nxt    = res_val_r;
    res_fnd_nxt    = res_fnd_r;
    res_err_nxt    = res_err_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(idx_r >> 3);
    ram_wdata      = byte_now;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    if (cfg_tvalid) begin
      size_nxt = cfg_tdata[SIZE_W-1:0];
    end
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = in_cmd;
          idx_nxt     = in_idx;
          res_bit_nxt = 1'b0;
          res_val_nxt = '0;
          res_fnd_nxt = 1'b0;
          res_err_nxt = 1'b0;
          acc_nxt     = '0;
          rd_byte_nxt = '0;
          nbytes_nxt  = nbytes;
          state_nxt   = S_DONE;
          case (in_cmd)
            CMD_TEST, CMD_SET, CMD_CLR: begin
              if ({1'b0, in_idx} >= used) begin
                res_err_nxt = 1'b1;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = in_addr;
                rvalid_nxt = valid_r[in_addr];
                state_nxt  = S_ACCESS;
              end
            end
            CMD_SET_ALL, CMD_CLR_ALL: begin
              valid_nxt = '0;
              fill_nxt  = (in_cmd == CMD_SET_ALL);
            end
            CMD_CNT_SET, CMD_CNT_CLR, CMD_FIND_SET, CMD_FIND_CLR: begin
              if (used != '0) begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                rvalid_nxt = valid_r[0];
                state_nxt  = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ACCESS: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_TEST: begin
            res_bit_nxt = byte_now[idx_r[2:0]];
          end
          CMD_SET: begin
            ram_we               = 1'b1;
            ram_wdata            = byte_now | (8'd1 << idx_r[2:0]);
            valid_nxt[ram_waddr] = 1'b1;
          end
          CMD_CLR: begin
            ram_we               = 1'b1;
            ram_wdata            = byte_now & ~(8'd1 << idx_r[2:0]);
            valid_nxt[ram_waddr] = 1'b1;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        if ((cmd_r == CMD_CNT_SET) || (cmd_r == CMD_CNT_CLR)) begin
          acc_nxt = acc_r + SIZE_W'(u_res.cnt);
          if (is_last) begin
            res_val_nxt = acc_r + SIZE_W'(u_res.cnt);
            state_nxt   = S_DONE;
          end
        end else if (u_res.hit) begin
          res_fnd_nxt = 1'b1;
          res_val_nxt = find_idx[SIZE_W-1:0];
          state_nxt   = S_DONE;
        end else if (is_last) begin
          state_nxt = S_DONE;
        end
        if (state_nxt == S_SCAN) begin
          rd_byte_nxt = next_byte;
          ram_re      = 1'b1;
          ram_raddr   = next_addr;
          rvalid_nxt  = valid_r[next_addr];
        end
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {2'b00, res_err_r, res_fnd_r, res_val_r, res_bit_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      size_r       <= SIZE_RST;
      fill_r       <= 1'b0;
      valid_r      <= '0;
      rvalid_r     <= 1'b0;
      rd_byte_r    <= '0;
      nbytes_r     <= '0;
      acc_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      size_r       <= size_nxt;
      fill_r       <= fill_nxt;
      valid_r      <= valid_nxt;
      rvalid_r     <= rvalid_nxt;
      rd_byte_r    <= rd_byte_nxt;
      nbytes_r     <= nbytes_nxt;
      acc_r        <= acc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    res_bit_r  <= res_bit_nxt;
    res_val_r  <= res_val_nxt;
    res_fnd_r  <= res_fnd_nxt;
    res_err_r  <= res_err_nxt;
    out_data_r <= out_data_nxt;
  end

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_byte_r < nbytes_r))
    else $error("scan past used bytes");

  a_access_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCESS) |-> ({1'b0, idx_r} < used))
    else $error("access beyond used size");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_data_r[11:1] <= used))
    else $error("result above used size");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_data_r[13]) |-> (out_data_r[12:0] == 13'd0))
    else $error("index error with other result fields set");

endmodule
